// File: design/pcs_pkg.sv
// package: shared constants and types for the percentile contrast stretch block
`default_nettype none
package pcs_pkg;
    localparam int COUNT_BITS_DEF = 22;
    localparam int NUM_BINS       = 256;
    localparam int BIN_BITS       = 8;
    localparam int FRAC_BITS      = 16;
    localparam logic [15:0] LOWER_FRACTION_RST = 16'd4588;
    localparam logic [15:0] UPPER_FRACTION_RST = 16'd60948;

    typedef enum logic [1:0] {
        MODE_COUNT   = 2'd0,
        MODE_CLOSE   = 2'd1,
        MODE_STRETCH = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        REG_LOWER = 1'b0,
        REG_UPPER = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SUM,
        ST_WALK,
        ST_DIV,
        ST_OUT
    } t_state;

    // floor(f*255/65536)
    function automatic logic [7:0] frac_level(input logic [15:0] f);
        logic [23:0] prod;
        begin
            prod = {8'd0, f} * 24'd255;
            frac_level = prod[23:16];
        end
    endfunction
endpackage
`default_nettype wire

// File: design/pcs_hist_ram.sv
// histogram memory: one write port, one registered read port
`default_nettype none
module pcs_hist_ram #(
    parameter int COUNT_BITS = pcs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [7:0]            i_waddr,
    input  wire logic [COUNT_BITS-1:0] i_wdata,
    input  wire logic [7:0]            i_raddr,
    output logic      [COUNT_BITS-1:0] o_rdata
);
    logic [COUNT_BITS-1:0] r_mem [pcs_pkg::NUM_BINS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/pcs_divider.sv
// stretch divider: restoring division, one quotient bit per cycle, round half even
`default_nettype none
module pcs_divider (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [7:0] i_pixel,
    input  wire logic [7:0] i_low,
    input  wire logic [7:0] i_high,
    output logic            o_done,
    output logic [7:0]      o_result
);
    // numerator magnitude up to 255*255 (16 bits), divisor up to 255
    logic [15:0] r_num;
    logic [15:0] n_num;
    logic [8:0]  r_rem;
    logic [8:0]  n_rem;
    logic [15:0] r_quo;
    logic [15:0] n_quo;
    logic [7:0]  r_den;
    logic        r_neg;
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [7:0]  r_result;
    logic        r_special;
    logic [7:0]  r_spec_val;

    logic signed [9:0]  diff_p;
    logic signed [9:0]  diff_d;
    logic        [16:0] prod;
    logic               neg_n;
    logic               neg_d;
    logic        [7:0]  mag_d;
    logic        [8:0]  mag_p;
    logic        [9:0]  trial;
    logic        [16:0] qf;
    logic               up;
    logic signed [18:0] qs;

    // setup values
    always_comb begin
        diff_p = $signed({2'b0, i_pixel}) - $signed({2'b0, i_low});
        diff_d = $signed({2'b0, i_high}) - $signed({2'b0, i_low});
        neg_n  = diff_p[9];
        neg_d  = diff_d[9];
        mag_p  = neg_n ? 9'(-diff_p) : diff_p[8:0];
        mag_d  = neg_d ? 8'(-diff_d) : diff_d[7:0];
        prod   = 17'(mag_p) * 17'd255;
    end

    // one restoring step
    always_comb begin
        trial = {r_rem, r_num[15]} - {2'b0, r_den};
        if (!trial[9]) begin
            n_rem = trial[8:0];
            n_quo = {r_quo[14:0], 1'b1};
        end else begin
            n_rem = {r_rem[7:0], r_num[15]};
            n_quo = {r_quo[14:0], 1'b0};
        end
        n_num = {r_num[14:0], 1'b0};
    end

    // floor and round half even of the signed result; clamped when registered
    always_comb begin
        if (!r_neg) begin
            up = ({r_rem, 1'b0} > {2'b0, r_den}) ||
                 (({r_rem, 1'b0} == {2'b0, r_den}) && r_quo[0]);
            qf = {1'b0, r_quo} + 17'(up);
            qs = $signed({2'b0, qf});
        end else begin
            // -(m/d): floor is -q-1 with remainder d-r when r != 0
            if (r_rem == 9'd0) begin
                qs = -$signed({2'b0, 1'b0, r_quo});
            end else begin
                qs = -$signed({2'b0, 1'b0, r_quo}) - 19'sd1;
                up = ({(9'(r_den) - r_rem), 1'b0} > {2'b0, r_den}) ||
                     (({(9'(r_den) - r_rem), 1'b0} == {2'b0, r_den}) && qs[0]);
                qs = qs + 19'(up);
            end
            qf = 17'd0;
            up = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_special  <= (mag_d == 8'd0);
                r_spec_val <= (i_pixel > i_low) ? 8'd255 : 8'd0;
                r_num      <= prod[15:0];
                r_neg      <= neg_n ^ neg_d;
                r_den      <= (mag_d == 8'd0) ? 8'd1 : mag_d;
                r_rem      <= 9'd0;
                r_quo      <= 16'd0;
                r_cnt      <= 5'd0;
                r_busy     <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_special) begin
                        r_result <= r_spec_val;
                    end else if (qs < 0) begin
                        r_result <= 8'd0;
                    end else if (qs > 19'sd255) begin
                        r_result <= 8'd255;
                    end else begin
                        r_result <= qs[7:0];
                    end
                end else begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 5'd1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;
endmodule
`default_nettype wire

// File: design/percentile_contrast_stretch.sv
// top level: histogram count, percentile search and pixel stretch
`default_nettype none
// Auto-contrast for one 8-bit channel; one item is taken at a time. A count item (mode 0)
// is a read-modify-write of the 256-entry histogram memory; a stretch item (mode 2)
// runs the bit-serial divider; a close item (mode 1) sweeps the memory twice (total,
// then cumulative walk with clearing). After reset the memory is cleared in a pass
// during which no item is accepted. The result waits in an output register until taken.
module percentile_contrast_stretch #(
    parameter int COUNT_BITS = pcs_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_pixel_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_pixel_out,
    output logic [7:0]       o_low_level,
    output logic [7:0]       o_high_level,
    output logic             o_frame_empty,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int SB = COUNT_BITS + 8;

    pcs_pkg::t_state r_state;
    pcs_pkg::t_state n_state;
    logic [15:0] r_lower;
    logic [15:0] r_upper;
    logic [7:0]  r_low;
    logic [7:0]  r_high;
    logic [COUNT_BITS-1:0] r_total;
    logic        r_clearing;
    logic [8:0]  r_idx;
    logic [7:0]  r_pix;
    logic [1:0]  r_ph;
    logic [SB-1:0] r_sum;
    logic [SB-1:0] r_cum;
    logic [SB+15:0] r_lo_t;
    logic [SB+15:0] r_hi_t;
    logic        r_found;
    logic [7:0]  r_nlow;
    logic [7:0]  r_nhigh;
    logic        r_ovalid;
    logic [7:0]  r_opix;
    logic        r_oempty;

    logic                  ram_we;
    logic [7:0]            ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [7:0]            ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  div_start;
    logic                  div_done;
    logic [7:0]            div_res;
    logic                  accept;
    logic [SB-1:0]         cum_next;
    logic [SB+15:0]        cum_sh;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != pcs_pkg::ST_IDLE) || r_clearing || r_ovalid;

    pcs_hist_ram #(.COUNT_BITS(COUNT_BITS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcs_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_pixel  (r_pix),
        .i_low    (r_low),
        .i_high   (r_high),
        .o_done   (div_done),
        .o_result (div_res)
    );

    assign cum_next = r_cum + SB'(ram_rdata);
    assign cum_sh   = {cum_next, 16'd0};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                if (accept) begin
                    case (pcs_pkg::t_mode'(i_mode))
                        pcs_pkg::MODE_COUNT:   n_state = pcs_pkg::ST_COUNT;
                        pcs_pkg::MODE_CLOSE:   n_state = pcs_pkg::ST_SUM;
                        pcs_pkg::MODE_STRETCH: n_state = pcs_pkg::ST_DIV;
                        default:               n_state = pcs_pkg::ST_OUT;
                    endcase
                end
            end
            pcs_pkg::ST_COUNT: if (r_ph == 2'd1) n_state = pcs_pkg::ST_OUT;
            pcs_pkg::ST_SUM:   if (r_idx == 9'd256) n_state = pcs_pkg::ST_WALK;
            pcs_pkg::ST_WALK:  if (r_idx == 9'd257) n_state = pcs_pkg::ST_OUT;
            pcs_pkg::ST_DIV:   if (div_done) n_state = pcs_pkg::ST_OUT;
            pcs_pkg::ST_OUT:   n_state = pcs_pkg::ST_IDLE;
            default:           n_state = pcs_pkg::ST_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pix;
        ram_wdata = '0;
        ram_raddr = r_pix;
        div_start = 1'b0;
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                ram_raddr = i_pixel_in;
                if (r_clearing) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[7:0];
                end
            end
            pcs_pkg::ST_COUNT: begin
                if (r_ph == 2'd1) begin
                    ram_we    = ram_rdata != CMAX;
                    ram_wdata = ram_rdata + COUNT_BITS'(1);
                end
            end
            pcs_pkg::ST_SUM:  ram_raddr = r_idx[7:0];
            pcs_pkg::ST_WALK: begin
                ram_raddr = r_idx[7:0];
                if (r_idx != 9'd0) begin
                    ram_we    = 1'b1;
                    ram_waddr = 8'(r_idx - 9'd1);
                end
            end
            pcs_pkg::ST_DIV: div_start = (r_ph == 2'd0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pcs_pkg::ST_IDLE;
            r_lower    <= pcs_pkg::LOWER_FRACTION_RST;
            r_upper    <= pcs_pkg::UPPER_FRACTION_RST;
            r_low      <= 8'd0;
            r_high     <= 8'd255;
            r_total    <= '0;
            r_clearing <= 1'b1;
            r_idx      <= 9'd0;
            r_ph       <= 2'd0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == pcs_pkg::REG_LOWER) r_lower <= i_cfg_data;
                else r_upper <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            // clearing pass after reset
            if (r_clearing) begin
                r_idx <= r_idx + 9'd1;
                if (r_idx == 9'd255) begin
                    r_clearing <= 1'b0;
                    r_idx      <= 9'd0;
                end
            end
            case (r_state)
                pcs_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_pix    <= i_pixel_in;
                        r_ph     <= 2'd0;
                        r_idx    <= 9'd0;
                        r_sum    <= '0;
                        r_cum    <= '0;
                        r_found  <= 1'b0;
                        r_opix   <= 8'd0;
                        r_oempty <= 1'b0;
                        r_nlow   <= pcs_pkg::frac_level(r_lower);
                        r_nhigh  <= pcs_pkg::frac_level(r_upper);
                    end
                end
                pcs_pkg::ST_COUNT: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd1 && r_total != CMAX) r_total <= r_total + COUNT_BITS'(1);
                end
                pcs_pkg::ST_SUM: begin
                    r_idx <= r_idx + 9'd1;
                    if (r_idx != 9'd0) r_sum <= r_sum + SB'(ram_rdata);
                    if (r_idx == 9'd256) begin
                        r_idx <= 9'd0;
                    end
                end
                pcs_pkg::ST_WALK: begin
                    // one multiply per threshold, done once
                    if (r_idx == 9'd0) begin
                        r_lo_t <= (SB+16)'(r_lower) * (SB+16)'(r_sum);
                        r_hi_t <= (SB+16)'(r_upper) * (SB+16)'(r_sum);
                    end else if (r_sum != '0) begin
                        r_cum <= cum_next;
                        if (!r_found && cum_sh >= r_lo_t) begin
                            r_nlow  <= 8'(r_idx - 9'd1);
                            r_found <= 1'b1;
                        end
                        if (cum_sh <= r_hi_t) r_nhigh <= 8'(r_idx - 9'd1);
                    end
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'd257) begin
                        r_low    <= r_nlow;
                        r_high   <= r_nhigh;
                        r_oempty <= (r_sum == '0);
                        r_total  <= '0;
                    end
                end
                pcs_pkg::ST_DIV: begin
                    r_ph <= 2'd1;
                    if (div_done) r_opix <= div_res;
                end
                pcs_pkg::ST_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_out   = r_opix;
    assign o_low_level   = r_low;
    assign o_high_level  = r_high;
    assign o_frame_empty = r_oempty;

    // no item accepted during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !accept) else $error("item accepted while clearing");
    // a result only follows the output state
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == pcs_pkg::ST_OUT)) else $error("stray result");
    // pixel total saturates at its maximum instead of wrapping
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcs_pkg::ST_COUNT && r_ph == 2'd1 && r_total == CMAX) |=> r_total == CMAX)
        else $error("pixel total wrapped");
endmodule
`default_nettype wire

// File: tb/percentile_contrast_stretch_tb.sv
// testbench: percentile contrast stretch, histogram, level search and pixel stretch
`timescale 1ns / 1ps
module percentile_contrast_stretch_tb;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic [7:0] low_level;
        logic [7:0] high_level;
        logic       frame_empty;
    } t_result;

    typedef struct {
        pcs_pkg::t_mode mode;
        logic [7:0]     pixel;
        bit             typed;
        t_result        res;
    } t_row;

    localparam int CMAX = (1 << pcs_pkg::COUNT_BITS_DEF) - 1;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [7:0]  i_pixel_in;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_pixel_out;
    logic [7:0]  o_low_level;
    logic [7:0]  o_high_level;
    logic        o_frame_empty;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // predictor state
    logic [15:0] lower_frac;
    logic [15:0] upper_frac;
    int unsigned hist[256];
    logic [7:0]  lvl_low;
    logic [7:0]  lvl_high;

    t_result     expected_q[$];
    int          errors;
    int          idle_cycles;
    int          accepted_in;
    int          accepted_out;
    int          frames_closed;
    int          stretched;
    int          send_idle_pct;
    int          recv_stall_pct;

    percentile_contrast_stretch dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_pixel_in(i_pixel_in), .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_out(o_pixel_out), .o_low_level(o_low_level),
        .o_high_level(o_high_level), .o_frame_empty(o_frame_empty),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] level_of_fraction(input logic [15:0] f);
        longint unsigned p;
        p = longint'(f) * 255;
        return p[23:16];
    endfunction

    // stretch with round half to even, clamped
    function automatic logic [7:0] stretch_pixel(input logic [7:0] p);
        longint num, den, q, r;
        num = 255 * (longint'(p) - longint'(lvl_low));
        den = longint'(lvl_high) - longint'(lvl_low);
        if (den == 0) return (p > lvl_low) ? 8'd255 : 8'd0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        q = num / den;
        r = num - q * den;
        if (r < 0) begin
            q = q - 1;
            r = r + den;
        end
        if (2 * r > den || (2 * r == den && q[0])) q = q + 1;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    // advance the histogram model by one item and return its result
    function automatic t_result predict_item(input pcs_pkg::t_mode m, input logic [7:0] p);
        t_result res;
        longint unsigned total, cum;
        bit found;
        logic [7:0] nl, nh;
        res = '0;
        case (m)
            pcs_pkg::MODE_COUNT: begin
                if (hist[p] < CMAX) hist[p]++;
            end
            pcs_pkg::MODE_CLOSE: begin
                total = 0;
                cum = 0;
                found = 0;
                nl = level_of_fraction(lower_frac);
                nh = level_of_fraction(upper_frac);
                foreach (hist[i]) total += hist[i];
                res.frame_empty = (total == 0);
                if (total != 0) begin
                    for (int i = 0; i < 256; i++) begin
                        cum += hist[i];
                        if (!found && (cum << 16) >= longint'(lower_frac) * total) begin
                            nl = i[7:0];
                            found = 1;
                        end
                        if ((cum << 16) <= longint'(upper_frac) * total) nh = i[7:0];
                    end
                end
                lvl_low = nl;
                lvl_high = nh;
                foreach (hist[i]) hist[i] = 0;
            end
            pcs_pkg::MODE_STRETCH: res.pixel_out = stretch_pixel(p);
            default: ;
        endcase
        res.low_level = lvl_low;
        res.high_level = lvl_high;
        return res;
    endfunction

    // receiver stall and result check
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            accepted_out++;
            if (expected_q.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_pixel_out !== want.pixel_out) begin
                    $error("pixel_out exp %0d got %0d", want.pixel_out, o_pixel_out);
                    errors++;
                end
                if (o_low_level !== want.low_level) begin
                    $error("low_level exp %0d got %0d", want.low_level, o_low_level);
                    errors++;
                end
                if (o_high_level !== want.high_level) begin
                    $error("high_level exp %0d got %0d", want.high_level, o_high_level);
                    errors++;
                end
                if (o_frame_empty !== want.frame_empty) begin
                    $error("frame_empty exp %0d got %0d", want.frame_empty,
                           o_frame_empty);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // send one item, with random idle before it
    task automatic send_item(input pcs_pkg::t_mode m, input logic [7:0] p, input bit typed,
                             input t_result typed_res);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid <= 1'b1;
        i_mode <= m;
        i_pixel_in <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = predict_item(m, p);
        if (typed && res !== typed_res) begin
            $error("table row mode %0d pixel %0d disagrees with predictor", m, p);
            errors++;
        end
        expected_q.push_back(res);
        accepted_in++;
        if (m == pcs_pkg::MODE_CLOSE) frames_closed++;
        if (m == pcs_pkg::MODE_STRETCH) stretched++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (expected_q.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_reg(input pcs_pkg::t_reg_idx idx, input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pcs_pkg::REG_LOWER) lower_frac = v;
        else upper_frac = v;
    endtask

    // one frame: count pixels with occasional random items, close, stretch a few
    task automatic random_frame(input int npix, input int spread);
        int base;
        base = $urandom_range(255);
        repeat (npix) begin
            if ($urandom_range(19) == 0)
                send_item(pcs_pkg::t_mode'($urandom_range(3)), 8'($urandom), 0, '0);
            else
                send_item(pcs_pkg::MODE_COUNT, 8'(base + $urandom_range(spread)), 0, '0);
        end
        send_item(pcs_pkg::MODE_CLOSE, 8'($urandom), 0, '0);
        repeat ($urandom_range(12, 4)) send_item(pcs_pkg::MODE_STRETCH, 8'($urandom), 0, '0);
    endtask

    t_row directed[$];
    logic [15:0] cfg_set[5][2] = '{
        '{16'd4588, 16'd60948}, '{16'd0, 16'd65535}, '{16'd65535, 16'd0},
        '{16'd32768, 16'd32768}, '{16'd1000, 16'd20000}};

    initial begin
        errors = 0; idle_cycles = 0; accepted_in = 0; accepted_out = 0;
        frames_closed = 0; stretched = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_mode = pcs_pkg::MODE_COUNT; i_pixel_in = '0;
        i_stall = 1'b0; i_cfg_we = 1'b0; i_cfg_index = pcs_pkg::REG_LOWER; i_cfg_data = '0;
        lower_frac = pcs_pkg::LOWER_FRACTION_RST;
        upper_frac = pcs_pkg::UPPER_FRACTION_RST;
        lvl_low = 8'd0;
        lvl_high = 8'd255;
        foreach (hist[i]) hist[i] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: reset levels, empty close, extremes, unused mode
        directed = '{
            '{pcs_pkg::MODE_STRETCH, 8'd0,   1, '{8'd0,   8'd0,  8'd255, 1'b0}},
            '{pcs_pkg::MODE_STRETCH, 8'd255, 1, '{8'd255, 8'd0,  8'd255, 1'b0}},
            '{pcs_pkg::MODE_STRETCH, 8'd128, 1, '{8'd128, 8'd0,  8'd255, 1'b0}},
            '{pcs_pkg::MODE_NONE,    8'd77,  1, '{8'd0,   8'd0,  8'd255, 1'b0}},
            '{pcs_pkg::MODE_CLOSE,   8'd0,   1, '{8'd0,   8'd17, 8'd237, 1'b1}},
            '{pcs_pkg::MODE_STRETCH, 8'd17,  1, '{8'd0,   8'd17, 8'd237, 1'b0}},
            '{pcs_pkg::MODE_STRETCH, 8'd0,   1, '{8'd0,   8'd17, 8'd237, 1'b0}},
            '{pcs_pkg::MODE_STRETCH, 8'd237, 1, '{8'd255, 8'd17, 8'd237, 1'b0}},
            '{pcs_pkg::MODE_STRETCH, 8'd255, 1, '{8'd255, 8'd17, 8'd237, 1'b0}},
            '{pcs_pkg::MODE_COUNT,   8'd0,   0, '0},
            '{pcs_pkg::MODE_COUNT,   8'd255, 0, '0},
            '{pcs_pkg::MODE_COUNT,   8'd255, 0, '0},
            '{pcs_pkg::MODE_COUNT,   8'd100, 0, '0},
            '{pcs_pkg::MODE_CLOSE,   8'd255, 0, '0},
            '{pcs_pkg::MODE_STRETCH, 8'd99,  0, '0},
            '{pcs_pkg::MODE_STRETCH, 8'd170, 0, '0},
            '{pcs_pkg::MODE_COUNT,   8'd42,  0, '0},
            '{pcs_pkg::MODE_CLOSE,   8'd0,   0, '0},
            '{pcs_pkg::MODE_STRETCH, 8'd42,  0, '0},
            '{pcs_pkg::MODE_STRETCH, 8'd43,  0, '0},
            '{pcs_pkg::MODE_STRETCH, 8'd41,  0, '0}};
        foreach (directed[i])
            send_item(directed[i].mode, directed[i].pixel, directed[i].typed,
                      directed[i].res);
        drain();

        // random part over settings and idling phases
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (ph < 5) begin
                write_reg(pcs_pkg::REG_LOWER, cfg_set[ph][0]);
                write_reg(pcs_pkg::REG_UPPER, cfg_set[ph][1]);
            end else if (ph % 3 == 0) begin
                write_reg(pcs_pkg::REG_LOWER, 16'($urandom));
                write_reg(pcs_pkg::REG_UPPER, 16'($urandom));
            end
            for (int f = 0; f < 4; f++)
                random_frame($urandom_range(40, 1), (f == 0) ? 255 : $urandom_range(30));
            if (ph == 7) drain();
            send_item(pcs_pkg::MODE_CLOSE, 8'($urandom), 0, '0);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("sent %0d items, checked %0d results: %0d frames closed, %0d stretches",
                 accepted_in, accepted_out, frames_closed, stretched);
        $display("fraction settings included zero, full scale, crossed and equal levels");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (expected_q.size() != 0)
                $error("%0d expected results never arrived", expected_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
